/* rtl/core/assert_macros.svh */
// Assertion macros used by row_log_sum_exp, the only asserting RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* rtl/core/rlse_pkg.sv */
// Package for the row log-sum-exp block: constants, state codes, tables.
// No dependencies.
package rlse_pkg;
    localparam int MAX_ROW_LEN = 1024;
    localparam int AW = $clog2(MAX_ROW_LEN);
    localparam int CW = $clog2(MAX_ROW_LEN + 1);
    localparam logic [31:0] LOG2E_Q30 = 32'h5C55_1D95;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_LOAD, ST_READ, ST_EXP, ST_NORM, ST_LOG, ST_LN, ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic        neg_inf;
        logic [31:0] u;
    } exp_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] term;
    } exp_rsp_t;

    function automatic logic [32:0] pow_tab(input logic [4:0] j);
        logic [32:0] r;
        case (j)
            5'd0:  r = 33'h080000000;
            5'd1:  r = 33'h0B504F333;
            5'd2:  r = 33'h0D744FCCA;
            5'd3:  r = 33'h0EAC0C6E7;
            5'd4:  r = 33'h0F5257D15;
            5'd5:  r = 33'h0FA83B2DB;
            5'd6:  r = 33'h0FD3E0C0C;
            5'd7:  r = 33'h0FE9E115C;
            5'd8:  r = 33'h0FF4ECB59;
            5'd9:  r = 33'h0FFA756B2;
            5'd10: r = 33'h0FFD3A751;
            5'd11: r = 33'h0FFE9D2B2;
            5'd12: r = 33'h0FFF4E8DE;
            5'd13: r = 33'h0FFFA7470;
            5'd14: r = 33'h0FFFD3A37;
            5'd15: r = 33'h0FFFE9D1B;
            5'd16: r = 33'h0FFFF4E8D;
            default: r = 33'h100000000;
        endcase
        return r;
    endfunction
endpackage

/* rtl/core/row_log_sum_exp.sv */
// After last, each stored element is read from the RAM and sent through the exp unit;
// then the log of the sum is taken, one result strobe; a row with no finite value gives -inf.
// Throughput: one element per cycle during loading; busy high in the pass.
// Set by the shared exp unit, one fraction bit per cycle, and the RAM port.
// Reset: asynchronous, clears row count, max and control; store is unset.
// Depends on rlse_pkg, rlse_ram, rlse_exp, assert_macros.svh.
`include "assert_macros.svh"
module row_log_sum_exp
    import rlse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        has_value,
    input  logic [31:0] value,
    input  logic        is_neg_inf,
    input  logic        last,
    output logic        done,
    output logic [31:0] result,
    output logic        result_neg_inf
);
    state_t st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic signed [31:0] max_reg, max_next;
    logic mninf_reg, mninf_next;
    logic [47:0] sum_reg, sum_next;
    logic [5:0] p_reg, p_next;
    logic [31:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0] step_reg, step_next;
    logic [31:0] res_reg, res_next;
    logic rninf_reg, rninf_next;
    logic done_reg, done_next;
    logic we;
    logic [AW-1:0] addr;
    logic [32:0] rdata;
    exp_req_t req;
    exp_rsp_t rsp;
    logic [63:0] sq;
    logic [48:0] add;
    logic [63:0] lnp;
    logic signed [33:0] rsum;
    logic accept;

    assign accept = start && !busy;
    assign busy = (st_reg != ST_LOAD);
    assign we = accept && has_value && (cnt_reg < CW'(MAX_ROW_LEN));
    assign addr = we ? cnt_reg[AW-1:0] : idx_reg[AW-1:0];

    rlse_ram #(.WIDTH(33), .DEPTH(MAX_ROW_LEN)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata({is_neg_inf, value}), .rdata(rdata)
    );

    assign req = {(st_reg == ST_EXP) && (step_reg == 5'd0), rdata[32],
                  32'(max_reg - $signed(rdata[31:0]))};

    rlse_exp u_exp (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign sq = {32'd0, m_reg} * {32'd0, m_reg};
    assign add = {1'b0, sum_reg} + {16'd0, rsp.term};
    assign lnp = {{42{1'b0}}, p_reg - 6'd32, frac_reg} * 64'(LN2_Q32) + 64'h8000_0000;
    assign rsum = 34'(max_reg) + 34'($signed({2'b0, lnp[63:32]}));

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        max_next = max_reg;
        mninf_next = mninf_reg;
        sum_next = sum_reg;
        p_next = p_reg;
        m_next = m_reg;
        frac_next = frac_reg;
        step_next = step_reg;
        res_next = res_reg;
        rninf_next = rninf_reg;
        done_next = 1'b0;
        case (st_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (we)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                        if (!is_neg_inf && (mninf_reg || $signed(value) > max_reg))
                        begin
                            max_next = $signed(value);
                            mninf_next = 1'b0;
                        end
                    end
                    if (last)
                    begin
                        idx_next = '0;
                        sum_next = '0;
                        if (!(is_neg_inf ? mninf_reg : (mninf_reg && !we)))
                        begin
                            st_next = ST_READ;
                        end
                        else if (we && !is_neg_inf)
                        begin
                            st_next = ST_READ;
                        end
                        else
                        begin
                            st_next = ST_DONE;
                            res_next = '0;
                            rninf_next = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (idx_reg == cnt_reg)
                begin
                    st_next = ST_NORM;
                end
                else
                begin
                    st_next = ST_EXP;
                    step_next = 5'd0;
                end
            end
            ST_EXP:
            begin
                step_next = 5'd1;
                if (rsp.done)
                begin
                    sum_next = add[48] ? SUM_MAX : add[47:0];
                    idx_next = idx_reg + CW'(1);
                    st_next = ST_READ;
                end
            end
            ST_NORM:
            begin
                if (sum_reg[47:32] == 16'd0)
                begin
                    sum_next = 48'h1_0000_0000;
                    p_next = 6'd32;
                end
                else if (!sum_reg[p_reg] && p_reg > 6'd32)
                begin
                    p_next = p_reg - 6'd1;
                end
                else
                begin
                    m_next = 32'(sum_reg >> (p_reg - 6'd30));
                    frac_next = '0;
                    step_next = 5'd15;
                    st_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (sq[61:30] >= 32'h8000_0000)
                begin
                    m_next = sq[62:31];
                    frac_next[step_reg[3:0]] = 1'b1;
                end
                else
                begin
                    m_next = sq[61:30];
                end
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    st_next = ST_LN;
                end
            end
            ST_LN:
            begin
                res_next = (rsum > 34'sh7FFF_FFFF) ? 32'h7FFF_FFFF : rsum[31:0];
                rninf_next = 1'b0;
                st_next = ST_DONE;
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                cnt_next = '0;
                max_next = '0;
                mninf_next = 1'b1;
                st_next = ST_LOAD;
            end
            default: st_next = ST_LOAD;
        endcase
        if (st_reg == ST_NORM && st_next == ST_NORM && p_reg == 6'd0)
        begin
            p_next = 6'd47;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_LOAD;
            cnt_reg <= '0;
            max_reg <= '0;
            mninf_reg <= 1'b1;
            done_reg <= 1'b0;
            p_reg <= 6'd47;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            max_reg <= max_next;
            mninf_reg <= mninf_next;
            done_reg <= done_next;
            p_reg <= (st_reg == ST_READ) ? 6'd47 : p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        sum_reg <= sum_next;
        m_reg <= m_next;
        frac_reg <= frac_next;
        step_reg <= step_next;
        res_reg <= res_next;
        rninf_reg <= rninf_next;
    end

    assign done = done_reg;
    assign result = res_reg;
    assign result_neg_inf = rninf_reg;

    `ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_reg <= CW'(MAX_ROW_LEN))
    `ASSERT_IMPLIES(a_ninf_zero, done_reg && rninf_reg, res_reg == 32'd0)
    `ASSERT_IMPLIES(a_done_clears, done_reg, st_reg == ST_LOAD && cnt_reg == '0)
    `ASSERT_NEXT(a_last_busy, accept && last, busy)
endmodule

/* rtl/core/rlse_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module rlse_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/core/rlse_exp.sv */
// Iterative fixed-point exp(-u) unit, one fraction bit per cycle.
// Depends on rlse_pkg.
module rlse_exp
    import rlse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  exp_req_t req,
    output exp_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic [4:0]  bit_reg, bit_next;
    logic [32:0] r_reg, r_next;
    logic [15:0] f_reg, f_next;
    logic [15:0] k_reg, k_next;
    logic        zero_reg, zero_next;
    logic [63:0] t_full;
    logic [65:0] prod;
    logic [32:0] shifted;

    assign t_full = {32'd0, req.u} * {32'd0, LOG2E_Q30} + 64'h2000_0000;
    assign prod = {33'd0, r_reg} * {33'd0, pow_tab(5'd16 - bit_reg)};
    assign shifted = r_reg >> k_reg[5:0];

    always_comb
    begin
        busy_next = busy_reg;
        bit_next = bit_reg;
        r_next = r_reg;
        f_next = f_reg;
        k_next = k_reg;
        zero_next = zero_reg;
        rsp.done = 1'b0;
        rsp.term = 33'd0;
        if (req.start)
        begin
            busy_next = 1'b1;
            bit_next = 5'd0;
            r_next = 33'h100000000;
            f_next = t_full[45:30];
            k_next = t_full[61:46];
            zero_next = req.neg_inf || (req.u >= 32'h0018_0000);
        end
        else if (busy_reg)
        begin
            if (bit_reg == 5'd16)
            begin
                busy_next = 1'b0;
                rsp.done = 1'b1;
                rsp.term = (zero_reg || k_reg >= 16'd33) ? 33'd0 : shifted;
            end
            else
            begin
                if (f_reg[bit_reg[3:0]])
                begin
                    r_next = prod[64:32];
                end
                bit_next = bit_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        r_reg <= r_next;
        f_reg <= f_next;
        k_reg <= k_next;
        zero_reg <= zero_next;
    end
endmodule
